@@ design/khw_pkg.sv @@
// ----------------------------------------------------------------------------
// khw_pkg
// Shared types and constants of the kernel histogram weight map block.
// ----------------------------------------------------------------------------
package khw_pkg;

    localparam int VALUE_W  = 40;
    localparam int KW_W     = 24;
    localparam int SAMPLE_W = 8;
    localparam int RAW_BIN_W = 4;
    localparam int WEIGHT_W = 32;
    localparam int BIN_SHIFT = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ACC    = 2'd1,
        OP_WEIGHT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // One classified request as it sits in the queue between front and back.
    typedef struct packed {
        op_t                  op;
        logic                 ch;
        logic                 load_ok;
        logic [RAW_BIN_W-1:0] bin_load;
        logic [RAW_BIN_W-1:0] bin_g;
        logic [RAW_BIN_W-1:0] bin_r;
        logic [VALUE_W-1:0]   value;
        logic [KW_W-1:0]      kw;
    } req_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_CLEAR,
        B_READ,
        B_ACC,
        B_CHECK,
        B_WAIT
    } back_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_PREP,
        U_DIV,
        U_SQRT
    } unit_state_t;

endpackage

@@ design/kernel_histogram_weight_map_top.sv @@
// ----------------------------------------------------------------------------
// kernel_histogram_weight_map_top
// Mean-shift candidate weighting over green and red histograms.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; a two-entry queue lets
// up to two requests wait while one executes. A model load, a clear, an
// accumulate and a weight query with a zero candidate bin run without the
// shared iterative unit. Any other weight query runs through it: 4 multiply
// steps, one setup step, 64 quotient steps and 32 square-root steps, unless
// the setup step finds the quotient too wide and saturates the result. The
// weight result appears on pixel_weight and divide_by_zero for exactly one
// cycle with done high; the receiver cannot stall it, so it must capture the result in that cycle.
module kernel_histogram_weight_map_top #(
    parameter int BIN_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic        channel_select,
    input  logic [3:0]  bin_number,
    input  logic [39:0] model_value,
    input  logic [7:0]  green_sample,
    input  logic [7:0]  red_sample,
    input  logic [23:0] kernel_weight,
    output logic        done,
    output logic [31:0] pixel_weight,
    output logic        divide_by_zero
);
    import khw_pkg::*;

    req_t head;
    logic head_valid;
    logic pop;

    khw_front #(.BIN_COUNT(BIN_COUNT)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .channel_select(channel_select),
        .bin_number(bin_number), .model_value(model_value),
        .green_sample(green_sample), .red_sample(red_sample),
        .kernel_weight(kernel_weight),
        .head(head), .head_valid(head_valid), .pop(pop));

    khw_back #(.BIN_COUNT(BIN_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .head_valid(head_valid),
        .pop(pop), .done(done), .pixel_weight(pixel_weight),
        .divide_by_zero(divide_by_zero));

endmodule

@@ design/khw_ram.sv @@
// ----------------------------------------------------------------------------
// khw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module khw_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ design/khw_front.sv @@
// ----------------------------------------------------------------------------
// khw_front
// Accepts requests, bins the samples and queues them for the back end.
// ----------------------------------------------------------------------------
module khw_front #(
    parameter int BIN_COUNT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           operation,
    input  logic                 channel_select,
    input  logic [3:0]           bin_number,
    input  logic [39:0]          model_value,
    input  logic [7:0]           green_sample,
    input  logic [7:0]           red_sample,
    input  logic [23:0]          kernel_weight,
    output khw_pkg::req_t        head,
    output logic                 head_valid,
    input  logic                 pop
);
    import khw_pkg::*;

    function automatic logic [RAW_BIN_W-1:0] clamp_bin(input logic [SAMPLE_W-1:0] s);
        logic [8:0] b;
        b = {5'd0, s[SAMPLE_W-1:BIN_SHIFT]};
        if (b >= 9'(BIN_COUNT))
        begin
            b = 9'(BIN_COUNT - 1);
        end
        return b[RAW_BIN_W-1:0];
    endfunction

    req_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    req_t       req_in;
    logic       push;

    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy;
    assign head       = q_mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);

    always_comb
    begin
        req_in.op       = op_t'(operation);
        req_in.ch       = channel_select;
        req_in.load_ok  = ({5'd0, bin_number} < 9'(BIN_COUNT));
        req_in.bin_load = bin_number;
        req_in.bin_g    = clamp_bin(green_sample);
        req_in.bin_r    = clamp_bin(red_sample);
        req_in.value    = model_value;
        req_in.kw       = kernel_weight;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= req_in;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

@@ design/khw_divsqrt.sv @@
// ----------------------------------------------------------------------------
// khw_divsqrt
// Iterative unit: floor(sqrt(mg*mr*2^32 / (kg*kr))), saturated to 32 bits.
// ----------------------------------------------------------------------------
module khw_divsqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] mg,
    input  logic [39:0] mr,
    input  logic [39:0] kg,
    input  logic [39:0] kr,
    output logic        done,
    output logic [31:0] root
);
    import khw_pkg::*;

    unit_state_t state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [39:0] mg_reg, mr_reg, kg_reg, kr_reg;
    logic [39:0] mg_next, mr_next, kg_next, kr_next;
    logic [79:0] num_reg, num_next;
    logic [79:0] den_reg, den_next;
    logic [79:0] rem_reg, rem_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] root_reg, root_next;
    logic [32:0] srem_reg, srem_next;

    logic [39:0] mul_a;
    logic [39:0] mul_b;
    logic [19:0] mul_half;
    logic [59:0] prod;
    logic [79:0] prod_sh;
    logic [80:0] r2;
    logic        div_ge;
    logic [34:0] s2;
    logic [34:0] trial;
    logic        sq_ge;

    assign done = done_reg;
    assign root = root_reg;

    always_comb
    begin
        mul_a    = step_reg[1] ? kg_reg : mg_reg;
        mul_b    = step_reg[1] ? kr_reg : mr_reg;
        mul_half = step_reg[0] ? mul_b[39:20] : mul_b[19:0];
        prod     = mul_a * mul_half;
        prod_sh  = step_reg[0] ? {prod, 20'd0} : {20'd0, prod};
        r2       = {rem_reg, dvd_reg[63]};
        div_ge   = (r2 >= {1'b0, den_reg});
        s2       = {srem_reg, dvd_reg[63:62]};
        trial    = {1'b0, root_reg, 2'b01};
        sq_ge    = (s2 >= trial);
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        mg_next    = mg_reg;
        mr_next    = mr_reg;
        kg_next    = kg_reg;
        kr_next    = kr_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    mg_next    = mg;
                    mr_next    = mr;
                    kg_next    = kg;
                    kr_next    = kr;
                    num_next   = '0;
                    den_next   = '0;
                    step_next  = '0;
                    state_next = U_MUL;
                end
            end
            U_MUL:
            begin
                if (step_reg[1])
                begin
                    den_next = den_reg + prod_sh;
                end
                else
                begin
                    num_next = num_reg + prod_sh;
                end
                step_next = step_reg + 6'd1;
                if (step_reg[1:0] == 2'd3)
                begin
                    state_next = U_PREP;
                end
            end
            U_PREP:
            begin
                // The quotient needs more than 64 bits exactly when the top part
                // of the dividend already reaches the divisor.
                rem_next  = {32'd0, num_reg[79:32]};
                dvd_next  = {num_reg[31:0], 32'd0};
                step_next = '0;
                if ({32'd0, num_reg[79:32]} >= den_reg)
                begin
                    root_next  = '1;
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
                else
                begin
                    state_next = U_DIV;
                end
            end
            U_DIV:
            begin
                rem_next  = div_ge ? 80'(r2 - {1'b0, den_reg}) : r2[79:0];
                dvd_next  = {dvd_reg[62:0], div_ge};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd63)
                begin
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = U_SQRT;
                end
            end
            U_SQRT:
            begin
                srem_next = sq_ge ? 33'(s2 - trial) : s2[32:0];
                root_next = {root_reg[30:0], sq_ge};
                dvd_next  = {dvd_reg[61:0], 2'b00};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd31)
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mg_reg   <= mg_next;
        mr_reg   <= mr_next;
        kg_reg   <= kg_next;
        kr_reg   <= kr_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == U_IDLE))
        else $error("unit started while running");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == U_IDLE))
        else $error("unit done while still running");
`endif

endmodule

@@ design/khw_back.sv @@
// ----------------------------------------------------------------------------
// khw_back
// Executes queued requests: histogram storage, accumulation and weighting.
// ----------------------------------------------------------------------------
module khw_back #(
    parameter int BIN_COUNT = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  khw_pkg::req_t head,
    input  logic          head_valid,
    output logic          pop,
    output logic          done,
    output logic [31:0]   pixel_weight,
    output logic          divide_by_zero
);
    import khw_pkg::*;

    localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    back_state_t          state_reg, state_next;
    req_t                 ent_reg, ent_next;
    logic [BIN_COUNT-1:0] vld_g_reg, vld_g_next;
    logic [BIN_COUNT-1:0] vld_r_reg, vld_r_next;
    logic                 done_reg, done_next;
    logic [31:0]          pw_reg, pw_next;
    logic                 dz_reg, dz_next;

    logic [BIN_W-1:0]    idx_load;
    logic [BIN_W-1:0]    idx_g;
    logic [BIN_W-1:0]    idx_r;
    logic                we_mg, we_mr, we_cg, we_cr;
    logic [39:0]         mg_data, mr_data, cg_data, cr_data;
    logic [39:0]         kg, kr;
    logic [40:0]         sum_g, sum_r;
    logic [39:0]         new_g, new_r;
    logic                unit_start;
    logic                unit_done;
    logic [31:0]         unit_root;

    assign idx_load = BIN_W'(ent_reg.bin_load);
    assign idx_g    = BIN_W'(ent_reg.bin_g);
    assign idx_r    = BIN_W'(ent_reg.bin_r);

    assign done           = done_reg;
    assign pixel_weight   = pw_reg;
    assign divide_by_zero = dz_reg;

    khw_ram #(.WIDTH(VALUE_W), .DEPTH(BIN_COUNT)) u_model_g (
        .clk(clk), .we(we_mg), .waddr(idx_load), .wdata(ent_reg.value),
        .raddr(idx_g), .rdata(mg_data));
    khw_ram #(.WIDTH(VALUE_W), .DEPTH(BIN_COUNT)) u_model_r (
        .clk(clk), .we(we_mr), .waddr(idx_load), .wdata(ent_reg.value),
        .raddr(idx_r), .rdata(mr_data));
    khw_ram #(.WIDTH(VALUE_W), .DEPTH(BIN_COUNT)) u_cand_g (
        .clk(clk), .we(we_cg), .waddr(idx_g), .wdata(new_g),
        .raddr(idx_g), .rdata(cg_data));
    khw_ram #(.WIDTH(VALUE_W), .DEPTH(BIN_COUNT)) u_cand_r (
        .clk(clk), .we(we_cr), .waddr(idx_r), .wdata(new_r),
        .raddr(idx_r), .rdata(cr_data));

    khw_divsqrt u_unit (
        .clk(clk), .rst_n(rst_n), .start(unit_start),
        .mg(mg_data), .mr(mr_data), .kg(kg), .kr(kr),
        .done(unit_done), .root(unit_root));

    // A candidate bin not written since the last clear reads as zero.
    always_comb
    begin
        kg    = vld_g_reg[idx_g] ? cg_data : '0;
        kr    = vld_r_reg[idx_r] ? cr_data : '0;
        sum_g = {1'b0, kg} + {17'd0, ent_reg.kw};
        sum_r = {1'b0, kr} + {17'd0, ent_reg.kw};
        new_g = sum_g[40] ? '1 : sum_g[39:0];
        new_r = sum_r[40] ? '1 : sum_r[39:0];
    end

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        vld_g_next = vld_g_reg;
        vld_r_next = vld_r_reg;
        done_next  = 1'b0;
        pw_next    = pw_reg;
        dz_next    = dz_reg;
        pop        = 1'b0;
        we_mg      = 1'b0;
        we_mr      = 1'b0;
        we_cg      = 1'b0;
        we_cr      = 1'b0;
        unit_start = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    ent_next = head;
                    unique case (head.op)
                        OP_LOAD:   state_next = B_LOAD;
                        OP_CLEAR:  state_next = B_CLEAR;
                        OP_ACC:    state_next = B_READ;
                        OP_WEIGHT: state_next = B_READ;
                        default:   state_next = B_IDLE;
                    endcase
                end
            end
            B_LOAD:
            begin
                we_mg      = ent_reg.load_ok && !ent_reg.ch;
                we_mr      = ent_reg.load_ok && ent_reg.ch;
                state_next = B_IDLE;
            end
            B_CLEAR:
            begin
                vld_g_next = '0;
                vld_r_next = '0;
                state_next = B_IDLE;
            end
            B_READ:
            begin
                state_next = (ent_reg.op == OP_ACC) ? B_ACC : B_CHECK;
            end
            B_ACC:
            begin
                we_cg             = 1'b1;
                we_cr             = 1'b1;
                vld_g_next[idx_g] = 1'b1;
                vld_r_next[idx_r] = 1'b1;
                state_next        = B_IDLE;
            end
            B_CHECK:
            begin
                if (kg == '0 || kr == '0)
                begin
                    done_next  = 1'b1;
                    pw_next    = '1;
                    dz_next    = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    unit_start = 1'b1;
                    state_next = B_WAIT;
                end
            end
            B_WAIT:
            begin
                if (unit_done)
                begin
                    done_next  = 1'b1;
                    pw_next    = unit_root;
                    dz_next    = 1'b0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            vld_g_reg <= '0;
            vld_r_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_g_reg <= vld_g_next;
            vld_r_reg <= vld_r_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        pw_reg  <= pw_next;
        dz_reg  <= dz_next;
    end

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");
    a_flag_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && dz_reg) |-> (pw_reg == '1))
        else $error("zero candidate bin without saturated weight");
`endif

endmodule
